// ----- rtl/core/swarq_pkg.sv -----
// Package for the stop-and-wait ARQ sender core.
// Holds request and result types, operation and result codes, and reset values.
// Depends on nothing.
`timescale 1ns / 1ps
package swarq_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEER_ADDRESS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT  = 2'd3;

   localparam logic [1:0] OP_PAYLOAD = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_ACK     = 2'd2;

   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_DELIVERED = 2'd1;
   localparam logic [1:0] KIND_GAVE_UP   = 2'd2;

   localparam logic [7:0] FRAME_TYPE_DATA = 8'd1;
   localparam logic [7:0] FRAME_TYPE_ACK  = 8'd2;

   localparam logic [7:0]  OWN_ADDRESS_RESET  = 8'd1;
   localparam logic [7:0]  PEER_ADDRESS_RESET = 8'd0;
   localparam logic [3:0]  RETRY_LIMIT_RESET  = 4'd5;
   localparam logic [15:0] ACK_TIMEOUT_RESET  = 16'd4000;

   localparam logic [15:0] SUM_LOW_MASK  = 16'h00FF;
   localparam logic [15:0] SUM_HIGH_MASK = 16'hFF00;

   localparam int HEADER_BYTES  = 4;
   localparam int TRAILER_BYTES = 5;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_SEND,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic [7:0] ack_dest;
      logic [7:0] ack_type;
      logic [7:0] ack_seq;
      logic [7:0] ack_check;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       out_last;
      logic [7:0] seq_number;
   } rsp_type;

endpackage

// ----- rtl/core/swarq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used as the payload store of the ARQ sender core. No dependencies.
`timescale 1ns / 1ps
module swarq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/stop_and_wait_arq_sender_core.sv -----
// Top level of the stop-and-wait ARQ sender: control, checksums and CSRs.
// Depends on swarq_pkg and swarq_ram (payload store).
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  request   in         start && !busy            req_data  (swarq_pkg::req_type)
//  result    out        rsp_strobe, one cycle     rsp_data  (swarq_pkg::rsp_type)
//  csr       in         csr_valid && csr_ready    csr_index, csr_data
//
//  A request that causes no frame never raises busy; a request that sends a frame of
//  L payload bytes holds busy while the frame leaves one byte a cycle, each payload
//  byte read from the payload store in the cycle before its slot.
//  Results appear in the cycle after the request or the frame slot that produces them.
//  Reset is synchronous and needs no clearing pass; the result side cannot stall.
module stop_and_wait_arq_sender_core #(
   parameter int MAX_PAYLOAD = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  swarq_pkg::req_type                   req_data,
   output logic                                 rsp_strobe,
   output swarq_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swarq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swarq_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int PW = $clog2(MAX_PAYLOAD + swarq_pkg::HEADER_BYTES
                              + swarq_pkg::TRAILER_BYTES);

   swarq_pkg::state_type state_ff, state_in;
   logic [7:0]           own_ff, peer_ff;
   logic [3:0]           limit_ff;
   logic [15:0]          timeout_ff;
   logic [7:0]           seq_ff, seq_in;
   logic [3:0]           credits_ff, credits_in;
   logic [15:0]          tick_ff, tick_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [7:0]           xor_ff, xor_in;
   logic [15:0]          sum_ff, sum_in;
   logic [15:0]          wsum_ff, wsum_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   swarq_pkg::rsp_type   rsp_ff, rsp_in;

   logic                 accept;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic [7:0]           rd_data;
   logic [PW-1:0]        total;
   logic [PW-1:0]        rd_pos;
   logic [7:0]           frame_byte;
   logic                 last_pos;
   logic [15:0]          weighted;
   logic                 start_send, retry, deliver, give_up;

   swarq_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req_data.payload_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff == swarq_pkg::ST_SEND);
   assign csr_ready  = ~busy;
   assign accept     = start & ~busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign total   = PW'(len_ff) + PW'(swarq_pkg::HEADER_BYTES);
   assign rd_pos  = pos_ff - PW'(swarq_pkg::HEADER_BYTES - 1);
   assign rd_addr = rd_pos[AW-1:0];

   always_comb begin
      last_pos = 1'b0;
      priority if (pos_ff < PW'(swarq_pkg::HEADER_BYTES)) begin
         unique case (pos_ff[1:0])
            2'd0: frame_byte = own_ff;
            2'd1: frame_byte = peer_ff;
            2'd2: frame_byte = swarq_pkg::FRAME_TYPE_DATA;
            2'd3: frame_byte = seq_ff;
         endcase
      end else if (pos_ff < total) begin
         frame_byte = rd_data;
      end else if (pos_ff == total) begin
         frame_byte = xor_ff;
      end else if (pos_ff == total + PW'(1)) begin
         frame_byte = 8'(sum_ff & swarq_pkg::SUM_LOW_MASK);
      end else if (pos_ff == total + PW'(2)) begin
         frame_byte = 8'((sum_ff & swarq_pkg::SUM_HIGH_MASK) >> 8);
      end else if (pos_ff == total + PW'(3)) begin
         frame_byte = 8'(wsum_ff & swarq_pkg::SUM_LOW_MASK);
      end else begin
         frame_byte = 8'((wsum_ff & swarq_pkg::SUM_HIGH_MASK) >> 8);
         last_pos   = 1'b1;
      end
   end

   assign weighted = 16'(16'(frame_byte) * 16'(pos_ff + PW'(1)));

   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      credits_in    = credits_ff;
      tick_in       = tick_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      sum_in        = sum_ff;
      wsum_in       = wsum_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      start_send    = 1'b0;
      retry         = 1'b0;
      deliver       = 1'b0;
      give_up       = 1'b0;

      unique case (state_ff)
         swarq_pkg::ST_COLLECT: begin
            if (accept && req_data.operation == swarq_pkg::OP_PAYLOAD) begin
               if (len_ff < LW'(MAX_PAYLOAD)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + LW'(1);
               end
               start_send = req_data.payload_last;
            end
         end
         swarq_pkg::ST_SEND: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.out_kind   = swarq_pkg::KIND_BYTE;
            rsp_in.out_byte   = frame_byte;
            rsp_in.out_last   = last_pos;
            rsp_in.seq_number = seq_ff;
            if (pos_ff < total) begin
               xor_in  = xor_ff ^ frame_byte;
               sum_in  = sum_ff + 16'(frame_byte);
               wsum_in = wsum_ff + weighted;
            end
            pos_in = pos_ff + PW'(1);
            if (last_pos) begin
               state_in = swarq_pkg::ST_WAIT;
            end
         end
         swarq_pkg::ST_WAIT: begin
            if (accept && req_data.operation == swarq_pkg::OP_TICK) begin
               if (tick_ff >= timeout_ff) begin
                  retry = 1'b1;
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end else if (accept && req_data.operation == swarq_pkg::OP_ACK) begin
               if ((req_data.ack_type ^ req_data.ack_seq) != req_data.ack_check) begin
                  retry = 1'b1;
               end else if (req_data.ack_dest == own_ff
                            && req_data.ack_type == swarq_pkg::FRAME_TYPE_ACK
                            && req_data.ack_seq == seq_ff) begin
                  deliver = 1'b1;
               end
            end
         end
         default: begin
            state_in = swarq_pkg::ST_COLLECT;
         end
      endcase

      if (retry) begin
         if (credits_ff == 4'd0) begin
            give_up = 1'b1;
         end else begin
            start_send = 1'b1;
         end
      end

      if (start_send) begin
         state_in   = swarq_pkg::ST_SEND;
         pos_in     = '0;
         xor_in     = '0;
         sum_in     = '0;
         wsum_in    = '0;
         tick_in    = '0;
         credits_in = (credits_ff != 4'd0) ? credits_ff - 4'd1 : 4'd0;
      end

      if (deliver || give_up) begin
         rsp_strobe_in     = 1'b1;
         rsp_in.out_kind   = deliver ? swarq_pkg::KIND_DELIVERED : swarq_pkg::KIND_GAVE_UP;
         rsp_in.out_byte   = '0;
         rsp_in.out_last   = 1'b1;
         rsp_in.seq_number = seq_ff;
         seq_in            = seq_ff + 8'd1;
         credits_in        = limit_ff;
         len_in            = '0;
         tick_in           = '0;
         state_in          = swarq_pkg::ST_COLLECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= swarq_pkg::ST_COLLECT;
         seq_ff        <= '0;
         credits_ff    <= swarq_pkg::RETRY_LIMIT_RESET;
         tick_ff       <= '0;
         len_ff        <= '0;
         pos_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         credits_ff    <= credits_in;
         tick_ff       <= tick_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff  <= xor_in;
      sum_ff  <= sum_in;
      wsum_ff <= wsum_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff     <= swarq_pkg::OWN_ADDRESS_RESET;
         peer_ff    <= swarq_pkg::PEER_ADDRESS_RESET;
         limit_ff   <= swarq_pkg::RETRY_LIMIT_RESET;
         timeout_ff <= swarq_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            swarq_pkg::CSR_OWN_ADDRESS:  own_ff     <= csr_data[7:0];
            swarq_pkg::CSR_PEER_ADDRESS: peer_ff    <= csr_data[7:0];
            swarq_pkg::CSR_RETRY_LIMIT:  limit_ff   <= csr_data[3:0];
            swarq_pkg::CSR_ACK_TIMEOUT:  timeout_ff <= csr_data;
         endcase
      end
   end

endmodule
